FILE: sv/sgms_pkg.sv
// Shared types and constants of the scan-to-grid match scorer.
// No dependencies; every other file of the block but sgms_if imports this package.
package sgms_pkg;

  // cell store and scoring window
  localparam int STORE_CELLS = 65536;
  localparam int STORE_AW    = $clog2(STORE_CELLS);
  localparam int WIN_R       = 1;
  localparam int WIN_N       = 2 * WIN_R + 1;
  localparam int WIN_CELLS   = WIN_N * WIN_N;
  localparam int WIN_CW      = $clog2(WIN_N + 1);
  localparam int GOOD_W      = $clog2(WIN_CELLS + 1);

  // shared serial divider
  localparam int DIV_NW = 48;
  localparam int DIV_DW = 32;
  localparam int DIV_SW = 6;

  // percentage in Q7.8: 100 * 256
  localparam int PCT_W     = 15;
  localparam int PCT_SCALE = 25600;

  // input queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_POINT = 2'd1,
    OP_END   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ORIGIN_X  = 3'd0;
  localparam cfg_idx_t CFG_ORIGIN_Y  = 3'd1;
  localparam cfg_idx_t CFG_CELL_SIZE = 3'd2;
  localparam cfg_idx_t CFG_MAP_W     = 3'd3;
  localparam cfg_idx_t CFG_MAP_H     = 3'd4;
  localparam cfg_idx_t CFG_THRESH    = 3'd5;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic [30:0]        cell_size;
    logic [16:0]        map_width;
    logic [16:0]        map_height;
    logic [3:0]         hit_threshold;
  } cfg_t;

  // one classified word travelling from front to back
  typedef struct packed {
    op_t                op;
    logic [15:0]        cell_index;
    logic signed [7:0]  cell_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } entry_t;

endpackage

FILE: sv/sgms_if.sv
// Channel interfaces of the scan-to-grid match scorer: input words and results.
// Depends on nothing; payload fields follow the block's item layout.
interface sgms_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [15:0]        cell_index;
  logic signed [7:0]  cell_value;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;

  modport source(output valid, op, cell_index, cell_value, point_x, point_y, input ready);
  modport sink(input valid, op, cell_index, cell_value, point_x, point_y, output ready);
endinterface

interface sgms_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hit_total;
  logic [31:0] point_total;
  logic [14:0] match_percent;
  logic        percent_valid;

  modport source(output valid, hit_total, point_total, match_percent, percent_valid,
                 input ready);
  modport sink(input valid, hit_total, point_total, match_percent, percent_valid,
               output ready);
endinterface

FILE: sv/scan_to_grid_match_scorer_core.sv
// Top level of the scan-to-grid match scorer: configuration registers, front, queue, back.
// Depends on sgms_pkg, sgms_if, sgms_front, sgms_queue and sgms_back.
//
// Usage: words arrive on in_ch (valid/ready). A load word writes one signed cell of
// the row-major map; a point word is mapped to a cell and scored against the 3x3
// window around it; an end word produces one result word on out_ch with the hit
// and point totals and the hit percentage in Q7.8, then clears the totals.
// Points and ends that arrive before any map load are dropped, as is op code 3.
// Registers are written through cfg_we/cfg_index/cfg_data. The user must write them only
// while the block is idle; the block itself does not enforce this.
// In the back end a load is written to the cell memory as it is popped. A point runs two
// coordinate divisions in the shared serial divider, then a window scan and drain through
// the cell memory's single read port. An end runs the 48-step percentage division, which
// an end with no points skips. The back takes its next word only once back in idle.
// A two-word queue lets the front keep accepting until it is full while the back works or
// while a result waits; a stalled receiver holds the result register, and the back stalls
// only when a second end word reaches it. Synchronous reset clears counters, the map
// flag and the queue; the cell store is not cleared and no clearing pass is run.
module scan_to_grid_match_scorer_core
  import sgms_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  sgms_in_if.sink           in_ch,
  sgms_out_if.source        out_ch,
  input  logic              cfg_we,
  input  cfg_idx_t          cfg_index,
  input  logic [31:0]       cfg_data
);

  cfg_t   cfg_r;
  logic   q_push, q_full;
  entry_t push_data, head;
  logic   empty, pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x      <= '0;
      cfg_r.origin_y      <= '0;
      cfg_r.cell_size     <= 31'd3277;
      cfg_r.map_width     <= 17'd256;
      cfg_r.map_height    <= 17'd256;
      cfg_r.hit_threshold <= 4'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORIGIN_X:  cfg_r.origin_x      <= cfg_data;
        CFG_ORIGIN_Y:  cfg_r.origin_y      <= cfg_data;
        CFG_CELL_SIZE: cfg_r.cell_size     <= cfg_data[30:0];
        CFG_MAP_W:     cfg_r.map_width     <= cfg_data[16:0];
        CFG_MAP_H:     cfg_r.map_height    <= cfg_data[16:0];
        CFG_THRESH:    cfg_r.hit_threshold <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  sgms_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .push      (q_push),
    .full      (q_full),
    .push_data (push_data)
  );

  sgms_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .full      (q_full),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  sgms_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // result consistency
  a_pct_cap : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.match_percent <= 15'(PCT_SCALE))
    else $error("match percentage above cap");

  a_pct_flag : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.percent_valid == (out_ch.point_total != '0)))
    else $error("percent_valid disagrees with point total");

  a_hits_le_points : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.hit_total <= out_ch.point_total)
    else $error("more hits than points");

endmodule

FILE: sv/sgms_queue.sv
// Short word queue between the front and the back of the scorer.
// Depends on sgms_pkg for the entry type and depth.
module sgms_queue
  import sgms_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  output logic   full,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t head,
  output logic   empty
);

  entry_t                slot_r [Q_DEPTH];
  logic [Q_AW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]         count_r;
  logic                  do_push, do_pop;

  assign full     = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign empty    = (count_r == '0);
  assign head     = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // store pushed words
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
    end
  end

endmodule

FILE: sv/sgms_front.sv
// Front of the scorer: accepts input words, drops those with no effect, queues the rest.
// Depends on sgms_pkg and the sgms_in_if channel interface.
module sgms_front
  import sgms_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  sgms_in_if.sink    in_ch,
  output logic       push,
  input  logic       full,
  output entry_t     push_data
);

  logic map_loaded_r;
  logic accept;
  logic idx_ok;
  op_t  op;

  assign op          = op_t'(in_ch.op);
  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign idx_ok      = (32'(in_ch.cell_index) < 32'(STORE_CELLS));

  // classify: keep valid loads, and points and ends once a map exists
  always_comb begin
    unique case (op)
      OP_LOAD:  push = accept && idx_ok;
      OP_POINT: push = accept && map_loaded_r;
      OP_END:   push = accept && map_loaded_r;
      default:  push = 1'b0;
    endcase
  end

  assign push_data.op         = op;
  assign push_data.cell_index = in_ch.cell_index;
  assign push_data.cell_value = in_ch.cell_value;
  assign push_data.point_x    = in_ch.point_x;
  assign push_data.point_y    = in_ch.point_y;

  // mark the map present after the first valid load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_loaded_r <= 1'b0;
    end else if (accept && op == OP_LOAD && idx_ok) begin
      map_loaded_r <= 1'b1;
    end
  end

endmodule

FILE: sv/sgms_div.sv
// Restoring divider, one quotient bit per cycle, shared by coordinates and percentage.
// Depends on sgms_pkg for its widths.
module sgms_div
  import sgms_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] dividend,
  input  logic [DIV_DW-1:0] divisor,
  input  logic [DIV_SW-1:0] steps,
  output logic              done,
  output logic [DIV_NW-1:0] quot
);

  logic              busy_r, done_r;
  logic [DIV_SW-1:0] cnt_r;
  logic [DIV_DW:0]   rem_r;
  logic [DIV_NW-1:0] q_r;
  logic [DIV_DW-1:0] dvs_r;
  logic [DIV_DW:0]   trial;
  logic              ge;

  assign trial = {rem_r[DIV_DW-1:0], q_r[DIV_NW-1]};
  assign ge    = (trial >= {1'b0, dvs_r});
  assign done  = done_r;
  assign quot  = q_r;

  // datapath: shift in one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? trial - {1'b0, dvs_r} : trial;
      q_r   <= {q_r[DIV_NW-2:0], ge};
    end
  end

  // step count and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_SW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/sgms_back.sv
// Back of the scorer: loads cells, maps and scores points, reports the cloud totals.
// Depends on sgms_pkg, sgms_div and the sgms_out_if channel interface.
module sgms_back
  import sgms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  entry_t      head,
  input  logic        empty,
  output logic        pop,
  sgms_out_if.source  out_ch
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIVX, S_DIVY, S_SCAN, S_DRAIN, S_PMUL, S_PDIV
  } state_t;

  state_t             state_r;
  logic               launch_r;
  logic signed [31:0] px_r, py_r;
  logic [15:0]        cx_r;
  logic               outx_r;
  logic [WIN_CW-1:0]  ix_r, iy_r;
  logic [GOOD_W-1:0]  good_r;
  logic [31:0]        hit_cnt_r, pt_cnt_r, hit_cap_r, pt_cap_r;
  logic [46:0]        prod_r;

  logic               out_valid_r, pct_valid_r;
  logic [31:0]        out_hit_r, out_pt_r;
  logic [PCT_W-1:0]   pct_r;

  // window pipeline: address stage, then read stage
  logic               v1_r, ok1_r, v2_r, ok2_r;
  logic [33:0]        addr1_r;
  logic signed [7:0]  rd_r;
  logic signed [7:0]  cell_mem [STORE_CELLS];

  logic               div_done;
  logic [DIV_NW-1:0]  div_quot, div_dividend;
  logic [DIV_DW-1:0]  div_divisor;
  logic [DIV_SW-1:0]  div_steps;

  logic [32:0]        diff;
  logic [31:0]        mag;
  logic               neg, off_grid;
  logic [16:0]        lim;
  logic [30:0]        csize;
  logic [18:0]        nx, ny;
  logic               in_nx, in_ny;
  logic [32:0]        row_base;
  logic [33:0]        addr;
  logic               mem_we;

  // offset of the point from the origin on the axis being divided
  always_comb begin
    if (state_r == S_DIVY) begin
      diff = 33'(py_r) - 33'(cfg.origin_y);
      lim  = cfg.map_height;
    end else begin
      diff = 33'(px_r) - 33'(cfg.origin_x);
      lim  = cfg.map_width;
    end
    neg      = diff[32];
    mag      = neg ? 32'(-diff) : diff[31:0];
    off_grid = (neg && div_quot[31:0] != '0) || (div_quot[31:0] >= 32'(lim));
  end

  // divider operands: cell size for coordinates, point count for percentage
  assign csize = (cfg.cell_size == '0) ? 31'd1 : cfg.cell_size;
  always_comb begin
    if (state_r == S_PDIV) begin
      div_dividend = DIV_NW'(prod_r);
      div_divisor  = pt_cap_r;
      div_steps    = DIV_SW'(DIV_NW);
    end else begin
      div_dividend = {mag, 16'd0};
      div_divisor  = DIV_DW'(csize);
      div_steps    = DIV_SW'(32);
    end
  end

  sgms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (launch_r),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .done     (div_done),
    .quot     (div_quot)
  );

  // neighbour cell position and row-major address
  always_comb begin
    nx       = 19'(cx_r) + 19'(ix_r) - 19'(WIN_R);
    ny       = 19'(py_r[15:0]) + 19'(iy_r) - 19'(WIN_R);
    in_nx    = !nx[18] && (nx[17:0] < 18'(cfg.map_width));
    in_ny    = !ny[18] && (ny[17:0] < 18'(cfg.map_height));
    row_base = 33'(ny[15:0]) * 33'(cfg.map_width);
    addr     = 34'(row_base) + 34'(nx[15:0]);
  end

  assign pop    = (state_r == S_IDLE) && !empty && (head.op != OP_END || !out_valid_r);
  assign mem_we = pop && head.op == OP_LOAD;

  // cell store: write on load, registered read for the window
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[STORE_AW'(head.cell_index)] <= head.cell_value;
    end
    rd_r <= cell_mem[addr1_r[STORE_AW-1:0]];
  end

  // window pipeline valid bits and address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= (state_r == S_SCAN);
      v2_r <= v1_r;
    end
    ok1_r   <= in_nx && in_ny && (addr < 34'(STORE_CELLS));
    addr1_r <= addr;
    ok2_r   <= ok1_r;
  end

  // sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      launch_r    <= 1'b0;
      hit_cnt_r   <= '0;
      pt_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      launch_r <= 1'b0;
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (v2_r && ok2_r && rd_r <= 8'sd0) begin
        good_r <= good_r + 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (pop) begin
            unique case (head.op)
              OP_POINT: begin
                px_r     <= head.point_x;
                py_r     <= head.point_y;
                pt_cnt_r <= (pt_cnt_r == '1) ? pt_cnt_r : pt_cnt_r + 1'b1;
                launch_r <= 1'b1;
                state_r  <= S_DIVX;
              end
              OP_END: begin
                hit_cnt_r <= '0;
                pt_cnt_r  <= '0;
                hit_cap_r <= hit_cnt_r;
                pt_cap_r  <= pt_cnt_r;
                if (pt_cnt_r == '0) begin
                  out_valid_r <= 1'b1;
                  out_hit_r   <= hit_cnt_r;
                  out_pt_r    <= '0;
                  pct_r       <= '0;
                  pct_valid_r <= 1'b0;
                end else begin
                  state_r <= S_PMUL;
                end
              end
              default: ;
            endcase
          end
        end
        S_DIVX: begin
          if (div_done) begin
            cx_r     <= div_quot[15:0];
            outx_r   <= off_grid;
            launch_r <= 1'b1;
            state_r  <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_done) begin
            // py_r now holds the cell row
            py_r   <= 32'(div_quot[15:0]);
            ix_r   <= '0;
            iy_r   <= '0;
            good_r <= '0;
            state_r <= (outx_r || off_grid) ? S_IDLE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (ix_r == WIN_CW'(WIN_N - 1)) begin
            ix_r <= '0;
            iy_r <= iy_r + 1'b1;
            if (iy_r == WIN_CW'(WIN_N - 1)) begin
              state_r <= S_DRAIN;
            end
          end else begin
            ix_r <= ix_r + 1'b1;
          end
        end
        S_DRAIN: begin
          if (!v1_r && !v2_r) begin
            if (8'(good_r) >= 8'(cfg.hit_threshold)) begin
              hit_cnt_r <= (hit_cnt_r == '1) ? hit_cnt_r : hit_cnt_r + 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        S_PMUL: begin
          prod_r   <= 47'(hit_cap_r) * 47'(PCT_SCALE);
          launch_r <= 1'b1;
          state_r  <= S_PDIV;
        end
        S_PDIV: begin
          if (div_done) begin
            out_valid_r <= 1'b1;
            out_hit_r   <= hit_cap_r;
            out_pt_r    <= pt_cap_r;
            pct_r       <= (div_quot > DIV_NW'(PCT_SCALE)) ? PCT_W'(PCT_SCALE)
                                                          : div_quot[PCT_W-1:0];
            pct_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.hit_total     = out_hit_r;
  assign out_ch.point_total   = out_pt_r;
  assign out_ch.match_percent = pct_r;
  assign out_ch.percent_valid = pct_valid_r;

endmodule

FILE: tb/scan_to_grid_match_scorer_core_tb.sv
// Testbench for scan_to_grid_match_scorer_core: directed and random words, scored against an
// in-bench model of the map, the point counters and the percentage division.
// Depends on sgms_pkg and the sgms_in_if / sgms_out_if interfaces.
`timescale 1ns / 100ps

module scan_to_grid_match_scorer_core_tb
  import sgms_pkg::*;
();

  localparam int CLK_PERIOD  = 20;
  localparam int DRAIN_WAIT  = 150;
  localparam int CYCLE_LIMIT = 2500000;

  typedef struct packed {
    logic [31:0] hit_total;
    logic [31:0] point_total;
    logic [14:0] match_percent;
    logic        percent_valid;
  } score_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [31:0] cfg_data;

  sgms_in_if  in_if ();
  sgms_out_if out_if ();

  scan_to_grid_match_scorer_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // mirror of the block's state
  logic signed [7:0] grid_cells [STORE_CELLS];
  bit                cell_set   [STORE_CELLS];
  bit                grid_loaded;
  logic [31:0]       hit_count;
  logic [31:0]       point_count;
  longint            org_x;
  longint            org_y;
  longint unsigned   cell_edge;
  longint            grid_w;
  longint            grid_h;
  int unsigned       min_good;

  score_t      pending_scores[$];
  int unsigned mismatches;
  int unsigned scores_seen;
  int unsigned words_sent;
  int unsigned points_sent;
  int unsigned cycles;
  bit          steady;

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("scan_to_grid_match_scorer_core verification failed");
      $finish;
    end
  end

  function automatic longint cell_coord(logic [31:0] p, longint org);
    longint div;
    div = (cell_edge == 0) ? 1 : longint'(cell_edge);
    return (longint'($signed(p)) - org) / div;
  endfunction

  function automatic bit on_grid(longint cx, longint cy);
    return cx >= 0 && cx < grid_w && cy >= 0 && cy < grid_h;
  endfunction

  function automatic logic [31:0] sat_inc(logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  // update the mirror for one accepted word, queue the result of an end word
  function automatic void accept_word(op_t op, logic [15:0] idx, logic signed [7:0] val,
                                      logic [31:0] px, logic [31:0] py);
    longint cx, cy, nx, ny, addr;
    int unsigned good;
    longint unsigned pct;
    score_t s;
    case (op)
      OP_LOAD: begin
        grid_cells[idx] = val;
        cell_set[idx] = 1'b1;
        grid_loaded = 1'b1;
      end
      OP_POINT: begin
        if (grid_loaded) begin
          cx = cell_coord(px, org_x);
          cy = cell_coord(py, org_y);
          point_count = sat_inc(point_count);
          if (on_grid(cx, cy)) begin
            good = 0;
            for (int dy = -WIN_R; dy <= WIN_R; dy++) begin
              for (int dx = -WIN_R; dx <= WIN_R; dx++) begin
                nx = cx + dx;
                ny = cy + dy;
                addr = ny * grid_w + nx;
                if (on_grid(nx, ny) && addr < STORE_CELLS && grid_cells[addr] <= 0)
                  good++;
              end
            end
            if (good >= min_good) hit_count = sat_inc(hit_count);
          end
        end
      end
      OP_END: begin
        if (grid_loaded) begin
          pct = 0;
          if (point_count != 0) begin
            pct = (longint'(hit_count) * PCT_SCALE) / longint'(point_count);
            if (pct > PCT_SCALE) pct = PCT_SCALE;
          end
          s.hit_total     = hit_count;
          s.point_total   = point_count;
          s.match_percent = pct[14:0];
          s.percent_valid = (point_count != 0);
          pending_scores.push_back(s);
          hit_count = 0;
          point_count = 0;
        end
      end
      default: ;
    endcase
  endfunction

  // send one word, at times with a random gap ahead of it (never when steady)
  task automatic send_word(op_t op, logic [15:0] idx, logic signed [7:0] val,
                           logic [31:0] px, logic [31:0] py);
    if (!steady && $urandom_range(99) < 26) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.op         <= op;
    in_if.cell_index <= idx;
    in_if.cell_value <= val;
    in_if.point_x    <= px;
    in_if.point_y    <= py;
    do @(posedge clk); while (!in_if.ready);
    accept_word(op, idx, val, px, py);
    words_sent++;
  endtask

  function automatic logic signed [7:0] rand_occupancy();
    case ($urandom_range(4))
      0: return -8'sd1;
      1: return 8'sd0;
      2: return 8'sd100;
      default: return 8'($urandom);
    endcase
  endfunction

  // load any unwritten cell of the point's window first, then send the point
  task automatic send_point(logic [31:0] px, logic [31:0] py);
    longint cx, cy, addr;
    if (grid_loaded) begin
      cx = cell_coord(px, org_x);
      cy = cell_coord(py, org_y);
      if (on_grid(cx, cy)) begin
        for (int dy = -WIN_R; dy <= WIN_R; dy++) begin
          for (int dx = -WIN_R; dx <= WIN_R; dx++) begin
            addr = (cy + dy) * grid_w + cx + dx;
            if (on_grid(cx + dx, cy + dy) && addr < STORE_CELLS && !cell_set[addr])
              send_word(OP_LOAD, addr[15:0], rand_occupancy(), '0, '0);
          end
        end
      end
    end
    send_word(OP_POINT, '0, '0, px, py);
    points_sent++;
  endtask

  // pick a coordinate whose cell lies near the grid, mostly near its edges
  function automatic logic [31:0] aim_coord(longint org, longint span);
    longint c, edge_len;
    edge_len = (cell_edge == 0) ? 1 : longint'(cell_edge);
    case ($urandom_range(2))
      0: c = longint'($urandom_range(4)) - 2;
      1: c = span + longint'($urandom_range(3)) - 2;
      default: c = (span > 0) ? longint'($urandom) % span : 0;
    endcase
    return 32'(org + c * edge_len + longint'($urandom) % edge_len);
  endfunction

  task automatic send_random_point();
    if ($urandom_range(9) < 8) send_point(aim_coord(org_x, grid_w), aim_coord(org_y, grid_h));
    else send_point($urandom, $urandom);
  endtask

  // lower valid and let the block go quiet
  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // write all six registers, one per cycle, block idle
  task automatic set_regs(logic [31:0] ox, logic [31:0] oy, logic [30:0] cs,
                          logic [16:0] w, logic [16:0] h, logic [3:0] th);
    logic [31:0] vals [6];
    vals = '{ox, oy, {1'b0, cs}, {15'd0, w}, {15'd0, h}, {28'd0, th}};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    org_x     = longint'($signed(ox));
    org_y     = longint'($signed(oy));
    cell_edge = cs;
    grid_w    = w;
    grid_h    = h;
    min_good  = th;
  endtask

  // receiver: check each result word, then choose ready for the next cycle
  always @(posedge clk) begin
    score_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.hit_total     = out_if.hit_total;
      got.point_total   = out_if.point_total;
      got.match_percent = out_if.match_percent;
      got.percent_valid = out_if.percent_valid;
      scores_seen++;
      if (pending_scores.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: hits %0d points %0d pct %0d valid %0d",
                   got.hit_total, got.point_total, got.match_percent, got.percent_valid);
      end else begin
        want = pending_scores.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     want.hit_total, want.point_total, want.match_percent,
                     want.percent_valid, got.hit_total, got.point_total,
                     got.match_percent, got.percent_valid);
        end
      end
    end
    out_if.ready <= steady || ($urandom_range(99) >= 26);
  end

  // nothing scored until a map exists; then an empty cloud
  task automatic test_no_map();
    send_word(OP_POINT, '0, '0, 32'd0, 32'd0);
    send_word(OP_END, '0, '0, '0, '0);
    send_word(OP_NONE, 16'hFFFF, -8'sd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_LOAD, 16'd0, 8'sd0, '0, '0);
    send_word(OP_END, '0, '0, '0, '0);
    drain();
  endtask

  // corners, value extremes and coordinate extremes under the reset settings
  task automatic test_directed();
    send_word(OP_LOAD, 16'd1, -8'sd128, '0, '0);
    send_word(OP_LOAD, 16'd256, 8'sd127, '0, '0);
    send_word(OP_LOAD, 16'd257, 8'sd100, '0, '0);
    send_word(OP_LOAD, 16'hFFFF, -8'sd1, '0, '0);
    send_point(32'd0, 32'd0);
    send_point(32'd3277 * 255, 32'd3277 * 255);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(-32'sd3000, 32'd100);
    send_word(OP_NONE, '0, '0, '0, '0);
    send_word(OP_END, '0, '0, '0, '0);
    send_word(OP_END, '0, '0, '0, '0);
    drain();
  endtask

  task automatic run_cloud(int unsigned n_words);
    for (int i = 0; i < n_words; i++) begin
      case ($urandom_range(19))
        0: send_word(OP_END, '0, '0, '0, '0);
        1: send_word(OP_LOAD, 16'($urandom), 8'($urandom), $urandom, $urandom);
        2: send_word(OP_NONE, 16'($urandom), 8'($urandom), $urandom, $urandom);
        default: send_random_point();
      endcase
    end
    send_word(OP_END, '0, '0, '0, '0);
    drain();
  endtask

  // extreme register settings
  task automatic test_extreme_regs();
    set_regs(32'h8000_0000, 32'h7FFF_FFFF, 31'd1, 17'd65536, 17'd1, 4'd0);
    run_cloud(25);
    set_regs(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 17'd1, 17'd65536, 4'd9);
    run_cloud(25);
    set_regs(32'd0, 32'd0, 31'd0, 17'd0, 17'd5, 4'd15);
    run_cloud(15);
    set_regs(32'd100, -32'sd100, 31'd40000, 17'd300, 17'd300, 4'd4);
    run_cloud(30);
    set_regs(32'd0, 32'd0, 31'd65536, 17'd131071, 17'd2, 4'd1);
    run_cloud(25);
  endtask

  // random settings, small maps, with one stretch of no idling
  task automatic test_random_clouds();
    for (int k = 0; k < 10; k++) begin
      steady = (k == 4);
      set_regs($urandom_range(0, 400000) - 200000, $urandom_range(0, 400000) - 200000,
               ($urandom_range(3) == 0) ? 31'($urandom_range(1, 20)) :
                                         31'($urandom_range(1000, 200000)),
               17'($urandom_range(1, 40)), 17'($urandom_range(1, 40)),
               4'($urandom_range(0, 10)));
      run_cloud(40);
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ORIGIN_X;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.op = OP_NONE;
    in_if.cell_index = '0;
    in_if.cell_value = '0;
    in_if.point_x = '0;
    in_if.point_y = '0;
    out_if.ready = 1'b0;
    steady = 1'b0;
    mismatches = 0;
    scores_seen = 0;
    words_sent = 0;
    points_sent = 0;
    grid_loaded = 1'b0;
    hit_count = '0;
    point_count = '0;
    org_x = 0;
    org_y = 0;
    cell_edge = 3277;
    grid_w = 256;
    grid_h = 256;
    min_good = 3;
    foreach (cell_set[i]) cell_set[i] = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_no_map();
    test_directed();
    test_extreme_regs();
    test_random_clouds();

    if (pending_scores.size() != 0) begin
      mismatches++;
      $display("%0d result words never arrived", pending_scores.size());
    end
    $display("covered %0d words (%0d points) and %0d result words over 16 register settings",
             words_sent, points_sent, scores_seen);
    if (mismatches == 0) begin
      $display("scan_to_grid_match_scorer_core verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("scan_to_grid_match_scorer_core verification failed");
    end
    $finish;
  end

endmodule

FILE: scan_to_grid_match_scorer_core.f
sv/sgms_pkg.sv
sv/sgms_if.sv
sv/sgms_queue.sv
sv/sgms_front.sv
sv/sgms_div.sv
sv/sgms_back.sv
sv/scan_to_grid_match_scorer_core.sv
tb/scan_to_grid_match_scorer_core_tb.sv
